// ===== rtl/core/lmr_pkg.sv =====
// shared constants and types of the local maximum and range filter
`timescale 1ns / 1ps
`default_nettype none

package lmr_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_RADIUS = 8;
  localparam int RING_ROWS  = 2 * MAX_RADIUS + 2;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = COL_W + 1;
  localparam int ROW_W  = $clog2(MAX_HEIGHT) + 1;
  localparam int RAD_W  = 4;
  localparam int RING_W = $clog2(RING_ROWS);
  localparam int ADDR_W = RING_W + COL_W;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 8'd3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic MODE_MAX   = 1'b0;
  localparam logic MODE_RANGE = 1'b1;

  // effective settings after clamping, plus a pulse that restarts the frame
  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [ROW_W-1:0] height;
    logic [RAD_W-1:0] radius;
    logic             mode;
    logic             restart;
  } lmr_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/lmr_cfg.sv =====
// configuration registers with clamping to the supported range
`timescale 1ns / 1ps
`default_nettype none

module lmr_cfg (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             wr_en,
  input  wire  [lmr_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire  [lmr_pkg::CFG_DATA_W-1:0]  wr_data,
  output lmr_pkg::lmr_cfg_t               cfg
);
  import lmr_pkg::*;

  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [3:0]  window_radius;
  logic        filter_mode;
  logic        restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= 11'd1024;
      frame_height  <= 13'd1024;
      window_radius <= 4'd1;
      filter_mode   <= MODE_RANGE;
      restart       <= 1'b0;
    end else begin
      restart <= 1'b0;
      if (wr_en) begin
        unique case (wr_index)
          REG_WIDTH: begin
            frame_width <= wr_data[10:0];
            restart     <= 1'b1;
          end
          REG_HEIGHT: begin
            frame_height <= wr_data[12:0];
            restart      <= 1'b1;
          end
          REG_RADIUS: begin
            window_radius <= wr_data[3:0];
            restart       <= 1'b1;
          end
          REG_MODE: begin
            filter_mode <= wr_data[0];
            restart     <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (frame_width == 11'd0)             cfg.width = WID_W'(1);
    else if (frame_width > 11'(MAX_WIDTH)) cfg.width = WID_W'(MAX_WIDTH);
    else                                  cfg.width = WID_W'(frame_width);
    if (frame_height == 13'd0)              cfg.height = ROW_W'(1);
    else if (frame_height > 13'(MAX_HEIGHT)) cfg.height = ROW_W'(MAX_HEIGHT);
    else                                    cfg.height = ROW_W'(frame_height);
    cfg.radius  = (window_radius > 4'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : window_radius;
    cfg.mode    = filter_mode;
    cfg.restart = restart;
  end

endmodule

`default_nettype wire

// ===== rtl/core/lmr_row_store.sv =====
// ring of line stores, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module lmr_row_store (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire  [lmr_pkg::ADDR_W-1:0]   wr_addr,
  input  wire  [7:0]                   wr_data,
  input  wire  [lmr_pkg::ADDR_W-1:0]   rd_addr,
  output logic [7:0]                   rd_data
);
  import lmr_pkg::*;

  logic [7:0] mem [RING_ROWS * MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/local_max_and_range_filter_unit.sv =====
// top level: frame position tracking, window scan and output register
//
// Grey pixels enter on the s_ stream in raster order; s_tuser marks a drain
// request that carries no pixel. Filtered pixels leave on the m_ stream in
// raster order, m_tlast flags the last pixel of a frame. The cfg channel
// writes frame width, height, window radius and filter mode by index; a
// write to any of these four registers restarts the frame.
// Each request is handled one at a time. A request that frees no output
// passes through CALC and TEST back to IDLE. One that completes an output
// also passes SCAN, LAST and EMIT; the clipped window holds up to 289
// pixels at radius 8, and since the line store ring has a single read port,
// the window is scanned one pixel per cycle.
// Reset clears frame position and restores the default settings; the
// line stores are not cleared and need none. A finished output waits in
// the output register while the next request is taken; a following window
// is still scanned, and its result then waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module local_max_and_range_filter_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] pixel
  input  wire  [0:0]  s_tuser,   // [0] op
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // [7:0] value
  output logic        m_tlast,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [lmr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [lmr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lmr_pkg::*;

  typedef enum logic [2:0] {IDLE, CALC, TEST, SCAN, LAST, EMIT} state_t;

  state_t state;
  lmr_cfg_t cfg;

  // receive position
  logic [ROW_W-1:0]  rrow;
  logic [COL_W-1:0]  rcol;
  logic [RING_W-1:0] rring;
  // emit position
  logic [ROW_W-1:0]  ey;
  logic [COL_W-1:0]  ex;
  logic [RING_W-1:0] ering;
  // window bounds
  logic [ROW_W-1:0]  wbot;
  logic [ROW_W-1:0]  wtop;
  logic [COL_W-1:0]  wright;
  logic [COL_W-1:0]  wleft;
  logic [RING_W-1:0] wring;
  // scan
  logic [ROW_W-1:0]  yy;
  logic [COL_W-1:0]  xx;
  logic [RING_W-1:0] ring;
  logic              rd_vld;
  logic [7:0]        vmax;
  logic [7:0]        vmin;
  logic [7:0]        rd_data;

  logic in_acc, cfg_acc, wr_en, out_free, ready;
  logic [ROW_W:0]    ry_sum;
  logic [WID_W:0]    rx_sum;
  logic [RAD_W-1:0]  dy;

  // no request while the frame restart of a register write is pending
  assign s_tready  = (state == IDLE) && !cfg_valid && !cfg.restart;
  assign cfg_ready = (state == IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign wr_en     = in_acc && (s_tuser[0] == OP_PIXEL) && (rrow < cfg.height);
  assign out_free  = !m_tvalid || m_tready;

  assign ry_sum = {1'b0, ey} + (ROW_W+1)'(cfg.radius);
  assign rx_sum = (WID_W+1)'(ex) + (WID_W+1)'(cfg.radius);
  assign dy     = (ey >= ROW_W'(cfg.radius)) ? cfg.radius : ey[RAD_W-1:0];
  // lexicographic compare of received position against the window corner
  assign ready  = (rrow > wbot) || ((rrow == wbot) && (rcol > wright));

  lmr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_acc),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lmr_row_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({rring, rcol}),
    .wr_data (s_tdata),
    .rd_addr ({ring, xx}),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      rrow     <= '0;
      rcol     <= '0;
      rring    <= '0;
      ey       <= '0;
      ex       <= '0;
      ering    <= '0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_vld <= (state == SCAN);
      if (rd_vld) begin
        if (rd_data > vmax) vmax <= rd_data;
        if (rd_data < vmin) vmin <= rd_data;
      end
      if (m_tready) m_tvalid <= 1'b0;

      unique case (state)
        IDLE: begin
          if (cfg.restart) begin
            rrow  <= '0;
            rcol  <= '0;
            rring <= '0;
            ey    <= '0;
            ex    <= '0;
            ering <= '0;
          end else if (in_acc) begin
            if (wr_en) begin
              if (WID_W'(rcol) == cfg.width - WID_W'(1)) begin
                rcol  <= '0;
                rrow  <= rrow + ROW_W'(1);
                rring <= (rring == RING_W'(RING_ROWS - 1)) ? '0 : rring + RING_W'(1);
              end else begin
                rcol <= rcol + COL_W'(1);
              end
            end
            state <= CALC;
          end
        end
        CALC: begin
          wbot   <= (ry_sum < (ROW_W+1)'(cfg.height)) ? ry_sum[ROW_W-1:0]
                                                      : cfg.height - ROW_W'(1);
          wright <= (rx_sum < (WID_W+1)'(cfg.width)) ? rx_sum[COL_W-1:0]
                                                     : COL_W'(cfg.width - WID_W'(1));
          wtop   <= ey - ROW_W'(dy);
          wleft  <= (ex >= COL_W'(cfg.radius)) ? ex - COL_W'(cfg.radius) : '0;
          wring  <= (ering >= RING_W'(dy)) ? ering - RING_W'(dy)
                                           : ering + RING_W'(RING_ROWS) - RING_W'(dy);
          state  <= TEST;
        end
        TEST: begin
          yy   <= wtop;
          xx   <= wleft;
          ring <= wring;
          vmax <= 8'h00;
          vmin <= 8'hff;
          state <= ready ? SCAN : IDLE;
        end
        SCAN: begin
          if (xx == wright) begin
            xx   <= wleft;
            yy   <= yy + ROW_W'(1);
            ring <= (ring == RING_W'(RING_ROWS - 1)) ? '0 : ring + RING_W'(1);
            if (yy == wbot) state <= LAST;
          end else begin
            xx <= xx + COL_W'(1);
          end
        end
        LAST: begin
          state <= EMIT;
        end
        EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= ((cfg.radius == '0) || (cfg.mode == MODE_MAX)) ? vmax : vmax - vmin;
            m_tlast  <= 1'b0;
            if (WID_W'(ex) == cfg.width - WID_W'(1)) begin
              ex    <= '0;
              ey    <= ey + ROW_W'(1);
              ering <= (ering == RING_W'(RING_ROWS - 1)) ? '0 : ering + RING_W'(1);
              if (ey == cfg.height - ROW_W'(1)) begin
                m_tlast <= 1'b1;
                ey      <= '0;
                ering   <= '0;
                rrow    <= '0;
                rcol    <= '0;
                rring   <= '0;
              end
            end else begin
              ex <= ex + COL_W'(1);
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // positions are cleared in the cycle after a register write takes effect
  a_rx_in_frame: assert property (@(posedge clk) disable iff (rst)
    !cfg.restart |-> (rrow <= cfg.height) && ((rrow < cfg.height) || (rcol == '0)))
    else $error("receive position beyond frame");

  a_emit_behind: assert property (@(posedge clk) disable iff (rst)
    !cfg.restart |-> (ey < cfg.height) && (WID_W'(ex) < cfg.width))
    else $error("emit position beyond frame");

  a_ring_range: assert property (@(posedge clk) disable iff (rst)
    (rring < RING_W'(RING_ROWS)) && (ering < RING_W'(RING_ROWS)))
    else $error("ring row index out of range");

  a_scan_ready: assert property (@(posedge clk) disable iff (rst)
    (state == TEST) && ready |=> (state == SCAN))
    else $error("ready window not scanned");

endmodule

`default_nettype wire
